// ===== hw/rtl/hcp16_pkg.sv =====
// Shared types and constants for the hex code point to UTF-16 converter.
// No dependencies; used by the top level, front end, job queue, back end and testbench.
`default_nettype none

package hcp16_pkg;

	localparam logic [15:0] CHAR_DOT         = 16'h002E;
	localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
	localparam logic [20:0] SURR_LOW_BOUND   = 21'h00D800;
	localparam logic [20:0] SURR_HIGH_BOUND  = 21'h00DFFF;
	localparam logic [20:0] BMP_MAX          = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE        = 21'h010000;
	localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// job kinds passed from front to back
	localparam logic [1:0] JOB_BMP   = 2'd0;
	localparam logic [1:0] JOB_PAIR  = 2'd1;
	localparam logic [1:0] JOB_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [20:0] value;
		logic        eot;
	} job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hcp16_if.sv =====
// Valid/ready channel interfaces for the converter's input and output sides.
// No dependencies.
`default_nettype none

interface hcp16_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] character;
	logic        final_char;

	modport source (output valid, output character, output final_char, input ready);
	modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface hcp16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        is_error;
	logic        end_of_text;

	modport source (output valid, output code_unit, output is_error, output end_of_text,
		input ready);
	modport sink   (input valid, input code_unit, input is_error, input end_of_text,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hex_code_points_to_utf16.sv =====
// Top level of the hex code point list to UTF-16 converter.
// Depends on hcp16_pkg, hcp16_if, hcp16_front, hcp16_fifo and hcp16_back.
//
// Accepts one character per cycle of a dot-separated hex code point text and
// returns UTF-16 words. A code point in the BMP gives one word; a supplementary
// code point gives a surrogate pair, which is sent as two words because the
// output register moves one word per cycle. A four-entry job queue sits between
// the parser and the output stage, so the input keeps flowing while a pair is
// sent or the sink stalls; input stalls only when that queue is full. The first
// word of a code point passes through the job queue and then the output register
// after the character that closes it is accepted. A bad text yields a single word
// with is_error and end_of_text set at its last character; words already sent
// for that text must be dropped by the sink.
`default_nettype none

module hex_code_points_to_utf16 (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hcp16_in_if.sink    chars,
	hcp16_out_if.source units
);

	hcp16_pkg::job_t push_job;
	hcp16_pkg::job_t head_job;
	logic            push;
	logic            full;
	logic            head_valid;
	logic            pop;

	hcp16_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.full   (full),
		.job    (push_job),
		.push   (push)
	);

	hcp16_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	hcp16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.units      (units)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/hcp16_front.sv =====
// Front end: parses characters, tracks segment state, pushes emit jobs.
// Depends on hcp16_pkg and hcp16_if.
`default_nettype none

module hcp16_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	hcp16_in_if.sink           chars,
	input  wire logic          full,
	output hcp16_pkg::job_t    job,
	output logic               push
);

	logic [20:0] acc_q;
	logic        empty_q;
	logic        err_q;

	logic [20:0] acc_n;
	logic        empty_n;
	logic        err_n;

	logic        is_dot;
	logic        dig_ok;
	logic [3:0]  dig;
	logic [24:0] nxt;
	logic        ovf;
	logic [20:0] close_val;
	logic        close_surr;
	logic        last;
	logic        accept;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;
	assign last        = chars.final_char;
	assign is_dot      = chars.character == hcp16_pkg::CHAR_DOT;

	always_comb begin
		dig_ok = 1'b1;
		dig    = 4'd0;
		if (chars.character >= 16'h0030 && chars.character <= 16'h0039) begin
			dig = chars.character[3:0];
		end else if ((chars.character >= 16'h0061 && chars.character <= 16'h0066) ||
				(chars.character >= 16'h0041 && chars.character <= 16'h0046)) begin
			dig = chars.character[3:0] + 4'd9;
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign nxt        = {acc_q, 4'b0000} + {21'd0, dig};
	assign ovf        = nxt > {4'd0, hcp16_pkg::MAX_CODE_POINT};
	assign close_val  = is_dot ? acc_q : nxt[20:0];
	assign close_surr = close_val >= hcp16_pkg::SURR_LOW_BOUND &&
		close_val <= hcp16_pkg::SURR_HIGH_BOUND;

	always_comb begin
		acc_n     = acc_q;
		empty_n   = empty_q;
		err_n     = err_q;
		push      = 1'b0;
		job.kind  = (close_val > hcp16_pkg::BMP_MAX) ? hcp16_pkg::JOB_PAIR
			: hcp16_pkg::JOB_BMP;
		job.value = close_val;
		job.eot   = last;
		if (!err_q) begin
			if (is_dot) begin
				if (empty_q || last) begin
					err_n = 1'b1;
				end else begin
					if (close_surr) begin
						err_n = 1'b1;
					end else begin
						push = 1'b1;
					end
					acc_n   = '0;
					empty_n = 1'b1;
				end
			end else if (!dig_ok || ovf) begin
				err_n = 1'b1;
			end else begin
				acc_n   = nxt[20:0];
				empty_n = 1'b0;
				if (last) begin
					if (close_surr) begin
						err_n = 1'b1;
					end else begin
						push = 1'b1;
					end
				end
			end
		end
		if (last) begin
			if (err_n) begin
				push      = 1'b1;
				job.kind  = hcp16_pkg::JOB_ERROR;
				job.value = '0;
				job.eot   = 1'b1;
			end
			acc_n   = '0;
			empty_n = 1'b1;
			err_n   = 1'b0;
		end
		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			empty_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (accept) begin
			acc_q   <= acc_n;
			empty_q <= empty_n;
			err_q   <= err_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hcp16_fifo.sv =====
// Short job queue between front and back ends.
// Depends on hcp16_pkg.
`default_nettype none

module hcp16_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  hcp16_pkg::job_t       push_job,
	input  wire logic             pop,
	output logic                  full,
	output logic                  head_valid,
	output hcp16_pkg::job_t       head_job
);

	hcp16_pkg::job_t                    mem_q [hcp16_pkg::QUEUE_DEPTH];
	logic [hcp16_pkg::QUEUE_IDX_W-1:0]  wr_ptr_q;
	logic [hcp16_pkg::QUEUE_IDX_W-1:0]  rd_ptr_q;
	logic [hcp16_pkg::QUEUE_CNT_W-1:0]  count_q;
	logic                               do_pop;

	assign full       = count_q == hcp16_pkg::QUEUE_CNT_W'(hcp16_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == hcp16_pkg::QUEUE_IDX_W'(hcp16_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == hcp16_pkg::QUEUE_IDX_W'(hcp16_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hcp16_back.sv =====
// Back end: turns queued jobs into UTF-16 words behind an output register.
// Depends on hcp16_pkg and hcp16_if.
`default_nettype none

module hcp16_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  hcp16_pkg::job_t    head_job,
	output logic               pop,
	hcp16_out_if.source        units
);

	logic        valid_q;
	logic [15:0] unit_q;
	logic        err_q;
	logic        eot_q;
	logic        phase_q;   // high surrogate of a pair already loaded into the output register

	logic        load;
	logic        first_half;
	logic [20:0] off;
	logic [15:0] unit_n;

	assign load       = !valid_q || units.ready;
	assign first_half = head_job.kind == hcp16_pkg::JOB_PAIR && !phase_q;
	assign pop        = load && head_valid && !first_half;
	assign off        = head_job.value - hcp16_pkg::SUPP_BASE;

	always_comb begin
		case (head_job.kind)
			hcp16_pkg::JOB_BMP:   unit_n = head_job.value[15:0];
			hcp16_pkg::JOB_PAIR:  unit_n = phase_q
				? hcp16_pkg::LOW_SURR_BASE + {6'd0, off[9:0]}
				: hcp16_pkg::HIGH_SURR_BASE + {6'd0, off[19:10]};
			default:              unit_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= first_half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			unit_q <= unit_n;
			err_q  <= head_job.kind == hcp16_pkg::JOB_ERROR;
			eot_q  <= head_job.eot && !first_half;
		end
	end

	assign units.valid       = valid_q;
	assign units.code_unit   = unit_q;
	assign units.is_error    = err_q;
	assign units.end_of_text = eot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hcp16_checker.sv =====
// Port-level assertions for hex_code_points_to_utf16, attached by bind.
// Depends on hcp16_if through the bound top level.
`default_nettype none

module hcp16_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] code_unit,
	input wire logic        is_error,
	input wire logic        end_of_text
);

	// stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit) &&
		$stable(is_error) && $stable(end_of_text))
		else $error("output word changed while stalled");

	// error word is zero and closes the text
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> code_unit == 16'h0000 && end_of_text)
		else $error("malformed error word");

	// a high surrogate never ends a text
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_error && code_unit[15:10] == 6'b110110 |-> !end_of_text)
		else $error("text ended on a high surrogate");

	// output idle once reset has been seen at an edge
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind hex_code_points_to_utf16 hcp16_checker u_hcp16_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (units.valid),
	.out_ready   (units.ready),
	.code_unit   (units.code_unit),
	.is_error    (units.is_error),
	.end_of_text (units.end_of_text)
);

`default_nettype wire

// ===== tb/hex_code_points_to_utf16_tb.sv =====
// Self-checking testbench for hex_code_points_to_utf16: random and directed code point texts
// go in, and every UTF-16 word that comes out is checked against an in-bench predictor.
// Depends on hcp16_pkg, hcp16_if and the converter RTL.
module hex_code_points_to_utf16_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 16;
	localparam int PHASE_ITEMS     = 200;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_error;
		logic        end_of_text;
	} utf16_word_t;

	typedef enum int {
		TXT_GOOD,
		TXT_LEAD_DOT,
		TXT_TRAIL_DOT,
		TXT_DOUBLE_DOT,
		TXT_BAD_CHAR,
		TXT_SURROGATE,
		TXT_OVERFLOW,
		TXT_NOISE
	} text_kind_e;

	// Tracks the converter's parse state and holds the words it should send next.
	class utf16_scoreboard;
		logic [20:0]  seg_value;
		bit           seg_empty;
		bit           text_bad;
		utf16_word_t  expected_q[$];
		int           errors;

		function new();
			clear_text();
			errors = 0;
		endfunction

		function void clear_text();
			seg_value = '0;
			seg_empty = 1'b1;
			text_bad  = 1'b0;
		endfunction

		function void queue_word(utf16_word_t w);
			expected_q.insert(expected_q.size(), w);
		endfunction

		// 0..15 for a hex digit of either case, 16 for anything else
		function int unsigned hex_digit(logic [15:0] c);
			if (c >= 16'h30 && c <= 16'h39) return 32'(c - 16'h30);
			if (c >= 16'h61 && c <= 16'h66) return 32'(c - 16'h61 + 16'd10);
			if (c >= 16'h41 && c <= 16'h46) return 32'(c - 16'h41 + 16'd10);
			return 16;
		endfunction

		// queues the closed segment as one word or a surrogate pair; 0 on a surrogate value
		function bit emit_point(bit eot);
			logic [20:0] offset;
			utf16_word_t w;
			if (seg_value >= hcp16_pkg::SURR_LOW_BOUND &&
					seg_value <= hcp16_pkg::SURR_HIGH_BOUND) return 1'b0;
			if (seg_value <= hcp16_pkg::BMP_MAX) begin
				w = '{seg_value[15:0], 1'b0, eot};
				queue_word(w);
				return 1'b1;
			end
			offset = seg_value - hcp16_pkg::SUPP_BASE;
			w = '{hcp16_pkg::HIGH_SURR_BASE + {6'd0, offset[19:10]}, 1'b0, 1'b0};
			queue_word(w);
			w = '{hcp16_pkg::LOW_SURR_BASE + {6'd0, offset[9:0]}, 1'b0, eot};
			queue_word(w);
			return 1'b1;
		endfunction

		function void note_char(logic [15:0] c, logic last);
			int unsigned d;
			utf16_word_t w;
			if (!text_bad) begin
				if (c == hcp16_pkg::CHAR_DOT) begin
					if (seg_empty || last) begin
						text_bad = 1'b1;
					end else begin
						if (!emit_point(1'b0)) text_bad = 1'b1;
						seg_value = '0;
						seg_empty = 1'b1;
					end
				end else begin
					d = hex_digit(c);
					if (d > 15 || seg_value > (32'(hcp16_pkg::MAX_CODE_POINT) - d) / 16) begin
						text_bad = 1'b1;
					end else begin
						seg_value = {seg_value[16:0], d[3:0]};
						seg_empty = 1'b0;
						if (last && !emit_point(1'b1)) text_bad = 1'b1;
					end
				end
			end
			if (last) begin
				if (text_bad) begin
					w = '{16'h0000, 1'b1, 1'b1};
					queue_word(w);
				end
				clear_text();
			end
		endfunction

		function void check_unit(logic [15:0] code_unit, logic is_error, logic end_of_text);
			utf16_word_t w;
			if (expected_q.size() == 0) begin
				$error("unexpected word: code_unit %h is_error %b end_of_text %b",
					code_unit, is_error, end_of_text);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			if (code_unit !== w.code_unit) begin
				$error("code_unit: expected %h, actual %h", w.code_unit, code_unit);
				errors++;
			end
			if (is_error !== w.is_error) begin
				$error("is_error: expected %b, actual %b", w.is_error, is_error);
				errors++;
			end
			if (end_of_text !== w.end_of_text) begin
				$error("end_of_text: expected %b, actual %b", w.end_of_text, end_of_text);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hcp16_in_if  chars_if ();
	hcp16_out_if units_if ();

	hex_code_points_to_utf16 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.units  (units_if)
	);

	utf16_scoreboard sb;
	logic [15:0]     text_chars[$];
	int              sender_idle_pct;
	int              receiver_stall_pct;
	int              hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		units_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				units_if.ready <= 1'b0;
			end else begin
				units_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready)
				sb.note_char(chars_if.character, chars_if.final_char);
			if (units_if.valid && units_if.ready)
				sb.check_unit(units_if.code_unit, units_if.is_error, units_if.end_of_text);
		end
	end

	task automatic send_char(logic [15:0] c, logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid      <= 1'b1;
		chars_if.character  <= c;
		chars_if.final_char <= last;
		do @(posedge clk); while (!chars_if.ready);
	endtask

	task automatic send_text();
		foreach (text_chars[i]) send_char(text_chars[i], i == text_chars.size() - 1);
	endtask

	function automatic void add_char(logic [15:0] c);
		text_chars.insert(text_chars.size(), c);
	endfunction

	function automatic logic [15:0] hex_char(int unsigned d);
		if (d < 10) return 16'(16'h30 + d);
		return 16'(($urandom_range(1) ? 16'h61 : 16'h41) + d - 10);
	endfunction

	function automatic logic [15:0] bad_char();
		logic [15:0] c;
		do c = 16'($urandom_range(16'hFFFF));
		while (sb.hex_digit(c) < 16 || c == hcp16_pkg::CHAR_DOT);
		return c;
	endfunction

	function automatic int unsigned rand_code_point();
		int unsigned edges[6] = '{32'h0, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'hD7FF, 32'hE000};
		case ($urandom_range(9))
			0: return edges[$urandom_range(5)];
			1, 2, 3, 4: return $urandom_range(1) ? $urandom_range(16'hD7FF) :
				$urandom_range(16'hFFFF, 16'hE000);
			9: return $urandom_range(32'h10FFFF);
			default: return $urandom_range(32'h10FFFF, 32'h10000);
		endcase
	endfunction

	function automatic void push_point(int unsigned cp);
		int nd;
		nd = 1;
		while (nd < 6 && (cp >> (4 * nd)) != 0) nd++;
		if ($urandom_range(3) == 0) nd += $urandom_range(2, 1);
		for (int k = nd - 1; k >= 0; k--) add_char(hex_char((cp >> (4 * k)) & 15));
	endfunction

	function automatic void build_text(text_kind_e kind);
		int nseg;
		int dbl_at;
		int bad_seg;
		int len;
		text_chars.delete();
		if (kind == TXT_NOISE) begin
			len = $urandom_range(8, 1);
			repeat (len) begin
				if ($urandom_range(1))
					add_char(16'($urandom_range(16'hFFFF)));
				else if ($urandom_range(3) == 0)
					add_char(hcp16_pkg::CHAR_DOT);
				else
					add_char(hex_char($urandom_range(15)));
			end
			return;
		end
		nseg = ($urandom_range(3) == 0) ? $urandom_range(6, 3) : $urandom_range(2, 1);
		if (kind == TXT_DOUBLE_DOT && nseg < 2) nseg = 2;
		dbl_at  = $urandom_range(nseg - 1, 1);
		bad_seg = $urandom_range(nseg - 1, 0);
		if (kind == TXT_LEAD_DOT) add_char(hcp16_pkg::CHAR_DOT);
		for (int i = 0; i < nseg; i++) begin
			if (i > 0) add_char(hcp16_pkg::CHAR_DOT);
			if (kind == TXT_DOUBLE_DOT && i == dbl_at) add_char(hcp16_pkg::CHAR_DOT);
			if (kind == TXT_SURROGATE && i == bad_seg) begin
				push_point($urandom_range(16'hDFFF, 16'hD800));
			end else if (kind == TXT_OVERFLOW && i == bad_seg) begin
				// 0x11xxxx or above trips the limit at the sixth digit
				add_char(hex_char(1));
				add_char(hex_char($urandom_range(15, 1)));
				repeat ($urandom_range(5, 4)) add_char(hex_char($urandom_range(15)));
			end else begin
				push_point(rand_code_point());
			end
		end
		if (kind == TXT_TRAIL_DOT) add_char(hcp16_pkg::CHAR_DOT);
		if (kind == TXT_BAD_CHAR)
			text_chars[$urandom_range(text_chars.size() - 1)] = bad_char();
	endfunction

	initial begin
		string directed_texts[8] = '{"0", "10FfFf", "110000", "D800", ".A", "a..B", "Ab.", "g"};
		int items;
		int target;
		int pick;
		text_kind_e kind;

		sb                  = new();
		sender_idle_pct     = 0;
		receiver_stall_pct  = 0;
		hold_left           = 0;
		items               = 0;
		arst_n              = 1'b0;
		chars_if.valid      = 1'b0;
		chars_if.character  = '0;
		chars_if.final_char = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_texts[t]) begin
			text_chars.delete();
			for (int i = 0; i < directed_texts[t].len(); i++)
				add_char({8'h00, directed_texts[t][i]});
			send_text();
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
				default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
			endcase
			// sender keeps offering while the output is held, so the job queue backs up
			if (phase % 2 == 0) hold_left = HOLD_OFF_CYCLES;
			target = items + PHASE_ITEMS;
			while (items < target) begin
				pick = $urandom_range(99);
				if (pick < 70) kind = TXT_GOOD;
				else if (pick < 90) kind = text_kind_e'($urandom_range(6, 1));
				else kind = TXT_NOISE;
				build_text(kind);
				send_text();
				items += text_chars.size();
			end
			chars_if.valid <= 1'b0;
			while (sb.pending() != 0) @(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
